>>> rtl/fwr_pkg.sv
// ----------------------------------------------------------------------------
// fwr_pkg
// Shared types and constants of the 3-D full-weighting restriction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fwr_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_GHOST  = 3'd3
  } fwr_reg_t;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET  = 7'd64;
  localparam logic [1:0]            GHOST_RESET = 2'd1;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  // per-sample control that travels down the pipeline
  typedef struct packed {
    logic emit;
    logic last;
  } fwr_tag_t;

endpackage

`default_nettype wire

>>> rtl/fwr_stream_if.sv
// ----------------------------------------------------------------------------
// fwr_stream_if
// Valid/ready channels of the restriction unit: fine input and coarse output.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwr_fine_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] fine_sample;

  modport source (output valid, output fine_sample, input ready);
  modport sink   (input valid, input fine_sample, output ready);
endinterface

interface fwr_coarse_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] coarse_value;
  logic                           coarse_last;

  modport source (output valid, output coarse_value, output coarse_last, input ready);
  modport sink   (input valid, input coarse_value, input coarse_last, output ready);
endinterface

`default_nettype wire

>>> rtl/fwr_ctrl.sv
// ----------------------------------------------------------------------------
// fwr_ctrl
// Configuration registers, stream position counters and window-close decode.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_ctrl #(
  parameter int MAX_COARSE_DIM = 64,
  parameter int MAX_GHOST      = 2,
  parameter int FW             = 8,
  parameter int AW             = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [fwr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fwr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                           accept,
  output logic [AW-1:0]                       plane_addr,
  output logic [FW-1:0]                       col,
  output fwr_pkg::fwr_tag_t                   tag
);
  import fwr_pkg::*;

  logic [CFG_DATA_W-1:0] size_x, size_y, size_z;
  logic [1:0]            ghost;
  logic [FW-1:0]         nx, ny, nz, g, fx, fy, fz;
  logic [FW-1:0]         p, r, c;
  logic [AW-1:0]         addr;
  logic                  hx, hy, hz, lx, ly, lz;

  function automatic logic [FW-1:0] clamp_size(input logic [CFG_DATA_W-1:0] raw);
    logic [FW-1:0] v;
    v = FW'(raw);
    if (raw == '0) v = FW'(1);
    else if (FW'(raw) > FW'(MAX_COARSE_DIM)) v = FW'(MAX_COARSE_DIM);
    return v;
  endfunction

  // window closes on this axis, and it is the last coarse index
  function automatic logic [1:0] axis_hit(input logic [FW-1:0] f, input logic [FW-1:0] gw,
                                          input logic [FW-1:0] n);
    logic [FW-1:0] d;
    logic          hit, lst;
    d   = f - gw - FW'(2);
    hit = (f >= gw + FW'(2)) && !d[0] && ({1'b0, d[FW-1:1]} < n);
    lst = hit && ({1'b0, d[FW-1:1]} == n - FW'(1));
    return {hit, lst};
  endfunction

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
      ghost  <= GHOST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        REG_GHOST:  ghost  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes and fine extents
  always_comb begin
    nx = clamp_size(size_x);
    ny = clamp_size(size_y);
    nz = clamp_size(size_z);
    g  = FW'(ghost);
    if (ghost == 2'd0) g = FW'(1);
    else if (FW'(ghost) > FW'(MAX_GHOST)) g = FW'(MAX_GHOST);
    fx = (nx << 1) + (g << 1);
    fy = (ny << 1) + (g << 1);
    fz = (nz << 1) + (g << 1);
  end

  // stream position
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      p    <= '0;
      r    <= '0;
      c    <= '0;
      addr <= '0;
    end else if (accept) begin
      if (c == fz - FW'(1)) begin
        c <= '0;
        if (r == fy - FW'(1)) begin
          r    <= '0;
          addr <= '0;
          p    <= (p == fx - FW'(1)) ? '0 : p + FW'(1);
        end else begin
          r    <= r + FW'(1);
          addr <= addr + AW'(1);
        end
      end else begin
        c    <= c + FW'(1);
        addr <= addr + AW'(1);
      end
    end
  end

  // window-close decode
  always_comb begin
    {hx, lx} = axis_hit(p, g, nx);
    {hy, ly} = axis_hit(r, g, ny);
    {hz, lz} = axis_hit(c, g, nz);
    tag.emit = hx && hy && hz;
    tag.last = lx && ly && lz;
    plane_addr = addr;
    col        = c;
  end

endmodule

`default_nettype wire

>>> rtl/fwr_plane_buf.sv
// ----------------------------------------------------------------------------
// fwr_plane_buf
// Plane memory: each entry keeps the two previous planes at one (row, column).
// Combines the three planes with weights 1, 2, 1.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_plane_buf #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FW           = 8,
  parameter int AW           = 16,
  parameter int DEPTH        = 17424
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   in_sample,
  input  wire logic [AW-1:0]                    in_addr,
  input  wire logic [FW-1:0]                    in_col,
  input  wire fwr_pkg::fwr_tag_t                in_tag,
  output logic                                  out_valid,
  output logic signed [SAMPLE_WIDTH+1:0]        out_sum,
  output logic [FW-1:0]                         out_col,
  output fwr_pkg::fwr_tag_t                     out_tag
);
  import fwr_pkg::*;

  localparam int W = SAMPLE_WIDTH;

  logic [2*W-1:0]        mem [DEPTH];
  logic [2*W-1:0]        rdata;
  logic                  s1_valid;
  logic signed [W-1:0]   s1_sample;
  logic [AW-1:0]         s1_addr;
  logic [FW-1:0]         s1_col;
  fwr_tag_t              s1_tag;
  logic signed [W-1:0]   prev1, prev2;

  // read the two older planes, write back shifted by one plane
  always_ff @(posedge clk) begin
    if (in_valid) rdata <= mem[in_addr];
    if (s1_valid) mem[s1_addr] <= {s1_sample, rdata[2*W-1:W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample <= in_sample;
    s1_addr   <= in_addr;
    s1_col    <= in_col;
    s1_tag    <= in_tag;
    out_col   <= s1_col;
    out_tag   <= s1_tag;
    out_sum   <= (W+2)'(prev2) + ((W+2)'(prev1) <<< 1) + (W+2)'(s1_sample);
  end

  // plane weights 1, 2, 1
  always_comb begin
    prev1 = rdata[2*W-1:W];
    prev2 = rdata[W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/fwr_row_buf.sv
// ----------------------------------------------------------------------------
// fwr_row_buf
// Row memory: each column entry keeps the plane sums of the two previous rows.
// Combines the three rows with weights 1, 2, 1.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_row_buf #(
  parameter int IW    = 34,
  parameter int FW    = 8,
  parameter int DEPTH = 132
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic signed [IW-1:0]  in_sum,
  input  wire logic [FW-1:0]         in_col,
  input  wire fwr_pkg::fwr_tag_t     in_tag,
  output logic                       out_valid,
  output logic signed [IW+1:0]       out_sum,
  output fwr_pkg::fwr_tag_t          out_tag
);
  import fwr_pkg::*;

  localparam int CW = $clog2(DEPTH);

  logic [2*IW-1:0]       mem [DEPTH];
  logic [2*IW-1:0]       rdata;
  logic                  s1_valid;
  logic signed [IW-1:0]  s1_sum;
  logic [FW-1:0]         s1_col;
  fwr_tag_t              s1_tag;
  logic signed [IW-1:0]  row1, row2;

  // read the two older rows, write back shifted by one row
  always_ff @(posedge clk) begin
    if (in_valid) rdata <= mem[in_col[CW-1:0]];
    if (s1_valid) mem[s1_col[CW-1:0]] <= {s1_sum, rdata[2*IW-1:IW]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sum  <= in_sum;
    s1_col  <= in_col;
    s1_tag  <= in_tag;
    out_tag <= s1_tag;
    out_sum <= (IW+2)'(row2) + ((IW+2)'(row1) <<< 1) + (IW+2)'(s1_sum);
  end

  // row weights 1, 2, 1
  always_comb begin
    row1 = rdata[2*IW-1:IW];
    row2 = rdata[IW-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/fwr_out_fifo.sv
// ----------------------------------------------------------------------------
// fwr_out_fifo
// Small result queue that decouples the pipeline from the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_out_fifo #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  push_value,
  input  wire logic                            push_last,
  output logic [fwr_pkg::FIFO_CNT_W-1:0]       count,
  fwr_coarse_if.source                         coarse_out
);
  import fwr_pkg::*;

  logic [SAMPLE_WIDTH:0]   entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic                    pop;

  assign pop = coarse_out.valid && coarse_out.ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= {push_last, push_value};
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  // head of queue
  always_comb begin
    coarse_out.valid        = (count != '0);
    coarse_out.coarse_value = entries[rd_ptr][SAMPLE_WIDTH-1:0];
    coarse_out.coarse_last  = entries[rd_ptr][SAMPLE_WIDTH];
  end

endmodule

`default_nettype wire

>>> rtl/full_weighting_restriction_3d_unit.sv
// ----------------------------------------------------------------------------
// full_weighting_restriction_3d_unit
// 27-point full-weighting restriction of a raster-streamed 3-D fine grid.
// ----------------------------------------------------------------------------
//  channel     dir  handshake     payload
//  fine_in     in   valid/ready   fine_sample
//  coarse_out  out  valid/ready   coarse_value, coarse_last
//  cfg         in   cfg_we        cfg_index, cfg_data
//
// One fine sample per cycle while fine_in.ready is high; a coarse value passes
// the plane, row and column stages after the sample that closes its window.
// The plane and row memories are each read and written once per sample.
// Synchronous reset clears control only; memories need no clearing.
// Input stalls only when the 8-entry result queue plus items in flight fill.
// ----------------------------------------------------------------------------
`default_nettype none

module full_weighting_restriction_3d_unit #(
  parameter int MAX_COARSE_DIM = 64,
  parameter int MAX_GHOST      = 2,
  parameter int SAMPLE_WIDTH   = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [fwr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fwr_pkg::CFG_DATA_W-1:0]  cfg_data,
  fwr_fine_if.sink                             fine_in,
  fwr_coarse_if.source                         coarse_out
);
  import fwr_pkg::*;

  localparam int W      = SAMPLE_WIDTH;
  localparam int FD     = 2 * MAX_COARSE_DIM + 2 * MAX_GHOST;
  localparam int FW     = $clog2(FD + 1) + 1;
  localparam int PDEPTH = FD * FD;
  localparam int AW     = $clog2(PDEPTH);
  localparam int PIPE_W = 3;

  logic                    accept;
  logic [AW-1:0]           plane_addr;
  logic [FW-1:0]           col;
  fwr_tag_t                tag;

  logic                    pl_valid;
  logic signed [W+1:0]     pl_sum;
  logic [FW-1:0]           pl_col;
  fwr_tag_t                pl_tag;

  logic                    rw_valid;
  logic signed [W+3:0]     rw_sum;
  fwr_tag_t                rw_tag;

  logic signed [W+3:0]     col1, col2;
  logic                    s5_valid;
  logic signed [W+5:0]     s5_sum;
  fwr_tag_t                s5_tag;

  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic [PIPE_W-1:0]       in_flight;

  // admit a sample only if its result is sure to find room
  assign fine_in.ready = ({1'b0, fifo_count} + (FIFO_CNT_W+1)'(in_flight))
                         < (FIFO_CNT_W+1)'(FIFO_DEPTH);
  assign accept = fine_in.valid && fine_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + PIPE_W'(accept) - PIPE_W'(s5_valid);
    end
  end

  fwr_ctrl #(
    .MAX_COARSE_DIM (MAX_COARSE_DIM),
    .MAX_GHOST      (MAX_GHOST),
    .FW             (FW),
    .AW             (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .plane_addr (plane_addr),
    .col        (col),
    .tag        (tag)
  );

  fwr_plane_buf #(
    .SAMPLE_WIDTH (W),
    .FW           (FW),
    .AW           (AW),
    .DEPTH        (PDEPTH)
  ) u_plane (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_sample (fine_in.fine_sample),
    .in_addr   (plane_addr),
    .in_col    (col),
    .in_tag    (tag),
    .out_valid (pl_valid),
    .out_sum   (pl_sum),
    .out_col   (pl_col),
    .out_tag   (pl_tag)
  );

  fwr_row_buf #(
    .IW    (W + 2),
    .FW    (FW),
    .DEPTH (FD)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pl_valid),
    .in_sum    (pl_sum),
    .in_col    (pl_col),
    .in_tag    (pl_tag),
    .out_valid (rw_valid),
    .out_sum   (rw_sum),
    .out_tag   (rw_tag)
  );

  // column weights 1, 2, 1 over the last three row sums
  always_ff @(posedge clk) begin
    if (rw_valid) begin
      col1 <= rw_sum;
      col2 <= col1;
    end
    s5_sum <= (W+6)'(col2) + ((W+6)'(col1) <<< 1) + (W+6)'(rw_sum);
    s5_tag <= rw_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= rw_valid;
    end
  end

  // divide by 64 with floor: drop the low six bits
  fwr_out_fifo #(
    .SAMPLE_WIDTH (W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s5_valid && s5_tag.emit),
    .push_value (s5_sum[W+5:6]),
    .push_last  (s5_tag.last),
    .count      (fifo_count),
    .coarse_out (coarse_out)
  );

endmodule

`default_nettype wire

>>> verif/tb_full_weighting_restriction_3d_unit.sv
// ----------------------------------------------------------------------------
// tb_full_weighting_restriction_3d_unit
// Streams fine grids through the restriction unit. An in-bench 27-point
// full-weighting predictor computes each coarse value, and a checker compares
// every coarse transaction with it, under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_full_weighting_restriction_3d_unit;
  import fwr_pkg::*;

  localparam int MAX_DIM   = 64;
  localparam int MAX_G     = 2;
  localparam int FINE_MAX  = 2 * MAX_DIM + 2 * MAX_G;
  localparam int DRAIN_GAP = 20;
  localparam int LIMIT     = 3000000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } coarse_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fwr_fine_if   #(.SAMPLE_WIDTH(32)) fine_if ();
  fwr_coarse_if #(.SAMPLE_WIDTH(32)) coarse_if ();

  full_weighting_restriction_3d_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fine_in    (fine_if.sink),
    .coarse_out (coarse_if.source)
  );

  // predictor state
  logic signed [31:0] fine_planes [3][FINE_MAX][FINE_MAX];
  int unsigned pos_plane, pos_row, pos_col;
  logic [6:0] size_x_reg, size_y_reg, size_z_reg;
  logic [1:0] ghost_reg;
  coarse_t coarse_expected [$];

  int errors;
  int unsigned cycle_count;
  int unsigned samples_sent;
  bit idling_on;
  int rx_hold_cycles;
  int rx_gap;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL full_weighting_restriction_3d_unit");
      $finish;
    end
  end

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // coarse index closed by fine coordinate f, or -1
  function automatic int closing_cell(int unsigned f, int unsigned g, int unsigned n);
    int unsigned d;
    if (f < g + 2) return -1;
    d = f - g - 2;
    if (d[0]) return -1;
    if ((d >> 1) >= n) return -1;
    return int'(d >> 1);
  endfunction

  // full-weighting prediction for one fine sample
  task automatic restrict_fine_sample(logic signed [31:0] sample);
    int unsigned cx, cy, cz, g, fx, fy, fz, p, r, c, off;
    int a, b, k;
    longint sum;
    coarse_t res;
    cx = clamp_range(size_x_reg, 1, MAX_DIM);
    cy = clamp_range(size_y_reg, 1, MAX_DIM);
    cz = clamp_range(size_z_reg, 1, MAX_DIM);
    g  = clamp_range(ghost_reg, 1, MAX_G);
    fx = 2 * cx + 2 * g;
    fy = 2 * cy + 2 * g;
    fz = 2 * cz + 2 * g;
    p = pos_plane; r = pos_row; c = pos_col;
    if (p >= fx || r >= fy || c >= fz) begin
      p = 0; r = 0; c = 0;
    end
    fine_planes[p % 3][r][c] = sample;
    a = closing_cell(p, g, cx);
    b = closing_cell(r, g, cy);
    k = closing_cell(c, g, cz);
    if (a >= 0 && b >= 0 && k >= 0) begin
      sum = 0;
      for (int dp = 0; dp < 3; dp++)
        for (int dr = 0; dr < 3; dr++)
          for (int dc = 0; dc < 3; dc++) begin
            off = (dp != 1) + (dr != 1) + (dc != 1);
            sum += longint'(8 >> off) *
                   longint'(fine_planes[(p - 2 + dp) % 3][r - 2 + dr][c - 2 + dc]);
          end
      sum = sum >>> 6;
      res.value = sum[31:0];
      res.last  = (a == cx - 1 && b == cy - 1 && k == cz - 1);
      coarse_expected.push_back(res);
    end
    c++;
    if (c == fz) begin
      c = 0;
      r++;
      if (r == fy) begin
        r = 0;
        p++;
        if (p == fx) p = 0;
      end
    end
    pos_plane = p; pos_row = r; pos_col = c;
  endtask

  // one fine transaction with a random lead-in gap
  task automatic send_sample(logic signed [31:0] sample);
    int gap;
    gap = idling_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      @(negedge clk) fine_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    fine_if.valid       <= 1'b1;
    fine_if.fine_sample <= sample;
    do @(posedge clk); while (!fine_if.ready);
    restrict_fine_sample(sample);
    samples_sent++;
  endtask

  // register write while idle; any write restarts the stream position
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    fine_if.valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SIZE_X: size_x_reg = data;
      REG_SIZE_Y: size_y_reg = data;
      REG_SIZE_Z: size_z_reg = data;
      REG_GHOST:  ghost_reg  = data[1:0];
      default: ;
    endcase
    pos_plane = 0; pos_row = 0; pos_col = 0;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic configure(int sx, int sy, int sz, int g);
    write_reg(REG_SIZE_X, CFG_DATA_W'(sx));
    write_reg(REG_SIZE_Y, CFG_DATA_W'(sy));
    write_reg(REG_SIZE_Z, CFG_DATA_W'(sz));
    write_reg(REG_GHOST, CFG_DATA_W'(g));
  endtask

  // wait for every expected coarse value, then for the pipeline tail
  task automatic wait_drain();
    @(negedge clk) fine_if.valid <= 1'b0;
    wait (coarse_expected.size() == 0);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  function automatic int unsigned grid_samples();
    int unsigned g;
    g = clamp_range(ghost_reg, 1, MAX_G);
    return (2 * clamp_range(size_x_reg, 1, MAX_DIM) + 2 * g) *
           (2 * clamp_range(size_y_reg, 1, MAX_DIM) + 2 * g) *
           (2 * clamp_range(size_z_reg, 1, MAX_DIM) + 2 * g);
  endfunction

  task automatic send_random_samples(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_sample($urandom());
  endtask

  // receiver ready: random gaps and commanded long hold-offs
  always @(negedge clk) begin
    if (!rst) begin
      if (rx_hold_cycles > 0) begin
        coarse_if.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_gap > 0) begin
        coarse_if.ready <= 1'b0;
        rx_gap--;
      end else begin
        coarse_if.ready <= 1'b1;
      end
    end
  end

  // coarse transaction checker
  always @(posedge clk) begin
    coarse_t exp_res;
    if (!rst && coarse_if.valid && coarse_if.ready) begin
      rx_gap = idling_on ? $urandom_range(0, 5) : 0;
      if (coarse_expected.size() == 0) begin
        $error("unexpected coarse transaction value=%h last=%b",
               coarse_if.coarse_value, coarse_if.coarse_last);
        errors++;
      end else begin
        exp_res = coarse_expected.pop_front();
        if (coarse_if.coarse_value !== exp_res.value) begin
          $error("coarse_value expected %h actual %h", exp_res.value, coarse_if.coarse_value);
          errors++;
        end
        if (coarse_if.coarse_last !== exp_res.last) begin
          $error("coarse_last expected %b actual %b", exp_res.last, coarse_if.coarse_last);
          errors++;
        end
      end
    end
  end

  // smallest grid with full-scale and alternating samples, then a wrap
  task automatic test_sample_extremes();
    configure(1, 1, 1, 1);
    repeat (64) send_sample(32'sh7fffffff);
    repeat (64) send_sample(32'sh80000000);
    for (int i = 0; i < 64; i++) send_sample(i[0] ? 32'sh80000000 : 32'sh7fffffff);
    send_random_samples(64);
    wait_drain();
  endtask

  // out-of-range sizes and ghost widths saturate; the oversized slow axis
  // is only streamed through its first planes
  task automatic test_saturation();
    configure(0, 0, 0, 0);
    send_random_samples(grid_samples());
    wait_drain();
    configure(1, 0, 1, 3);
    send_random_samples(grid_samples());
    wait_drain();
    configure(127, 1, 1, 1);
    send_random_samples(150);
    wait_drain();
  endtask

  // a write to an index past the list still restarts the stream
  task automatic test_restart_on_write();
    configure(2, 1, 2, 1);
    send_random_samples(100);
    wait_drain();
    write_reg(CFG_INDEX_W'(REG_GHOST + 3'd1), CFG_DATA_W'($urandom()));
    send_random_samples(grid_samples());
    wait_drain();
    send_random_samples(37);
    wait_drain();
    write_reg(CFG_INDEX_W'(REG_GHOST + 3'd4), CFG_DATA_W'($urandom()));
    send_random_samples(grid_samples());
    wait_drain();
  endtask

  // the largest size on the fastest axis uses 130 of the 132 row memory entries
  task automatic test_axis_extremes();
    configure(1, 1, 64, 1);
    send_random_samples(grid_samples());
    wait_drain();
  endtask

  // long receiver hold-off fills the result queue and stalls the input
  task automatic test_backpressure();
    configure(2, 2, 2, 1);
    @(negedge clk) rx_hold_cycles = 400;
    send_random_samples(grid_samples());
    wait_drain();
    idling_on = 1'b0;
    @(negedge clk) rx_hold_cycles = 300;
    send_random_samples(grid_samples());
    wait_drain();
    idling_on = 1'b1;
  endtask

  // random small grids: mostly whole grids, some cut short
  task automatic test_random_grids();
    int unsigned start;
    start = samples_sent;
    while (samples_sent - start < 300) begin
      configure($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3),
                $urandom_range(1, 2));
      idling_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0)
        send_random_samples($urandom_range(1, grid_samples() - 1));
      else
        send_random_samples(grid_samples());
      wait_drain();
    end
    idling_on = 1'b1;
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    samples_sent = 0;
    idling_on = 1'b1;
    rx_hold_cycles = 0;
    rx_gap = 0;
    size_x_reg = SIZE_RESET;
    size_y_reg = SIZE_RESET;
    size_z_reg = SIZE_RESET;
    ghost_reg  = GHOST_RESET;
    pos_plane = 0; pos_row = 0; pos_col = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_SIZE_X;
    cfg_data = '0;
    fine_if.valid = 1'b0;
    fine_if.fine_sample = '0;
    coarse_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_sample_extremes();
    test_saturation();
    test_restart_on_write();
    test_axis_extremes();
    test_backpressure();
    test_random_grids();

    wait_drain();
    if (errors == 0)
      $display("PASS full_weighting_restriction_3d_unit");
    else
      $display("FAIL full_weighting_restriction_3d_unit");
    $finish;
  end

endmodule
